/* hdl/tdpt_pkg.sv */
// Types, constants and microcode ROM for the trial division prime test.
`timescale 1ns / 1ps

package tdpt_pkg;

  localparam int VALUE_BITS_DEFAULT = 20;
  localparam int PC_BITS            = 4;

  typedef logic [PC_BITS-1:0] step_t;

  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_LT2       = 4'd1;
  localparam step_t S_EQ2       = 4'd2;
  localparam step_t S_EVEN      = 4'd3;
  localparam step_t S_INIT      = 4'd4;
  localparam step_t S_TRY       = 4'd5;
  localparam step_t S_DIV       = 4'd6;
  localparam step_t S_REM       = 4'd7;
  localparam step_t S_ADVANCE   = 4'd8;
  localparam step_t S_FAIL      = 4'd9;
  localparam step_t S_PASS      = 4'd10;
  localparam step_t S_EMIT      = 4'd11;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_INIT_D,
    ACT_DIV_START,
    ACT_DIV_STEP,
    ACT_NEXT_D,
    ACT_SET_FAIL,
    ACT_SET_PASS,
    ACT_EMIT
  } action_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_LT2,
    C_EQ2,
    C_EVEN,
    C_SQ_GT_N,
    C_DIV_LAST,
    C_REM_ZERO,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    action_t act;
    cond_t   cond;
    step_t   jump_true;
    step_t   jump_false;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t pc);
    ctrl_t w;
    unique case (pc)
      S_WAIT:    w = '{ACT_LOAD,      C_ACCEPT,   S_LT2,   S_WAIT};
      S_LT2:     w = '{ACT_NOP,       C_LT2,      S_FAIL,  S_EQ2};
      S_EQ2:     w = '{ACT_NOP,       C_EQ2,      S_PASS,  S_EVEN};
      S_EVEN:    w = '{ACT_NOP,       C_EVEN,     S_FAIL,  S_INIT};
      S_INIT:    w = '{ACT_INIT_D,    C_ALWAYS,   S_TRY,   S_TRY};
      S_TRY:     w = '{ACT_DIV_START, C_SQ_GT_N,  S_PASS,  S_DIV};
      S_DIV:     w = '{ACT_DIV_STEP,  C_DIV_LAST, S_REM,   S_DIV};
      S_REM:     w = '{ACT_NOP,       C_REM_ZERO, S_FAIL,  S_ADVANCE};
      S_ADVANCE: w = '{ACT_NEXT_D,    C_ALWAYS,   S_TRY,   S_TRY};
      S_FAIL:    w = '{ACT_SET_FAIL,  C_ALWAYS,   S_EMIT,  S_EMIT};
      S_PASS:    w = '{ACT_SET_PASS,  C_ALWAYS,   S_EMIT,  S_EMIT};
      S_EMIT:    w = '{ACT_EMIT,      C_OUT_FREE, S_WAIT,  S_EMIT};
      default:   w = '{ACT_NOP,       C_ALWAYS,   S_WAIT,  S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* hdl/trial_division_prime_test.sv */
// Top level: microcoded trial division primality test, one candidate per word.
`timescale 1ns / 1ps

// Takes one candidate word, returns one word with the verdict and the candidate echoed.
// Zero, one and even numbers are settled by the first checks; an odd candidate n is
// divided by 3, 5, 7, ... while the divisor squared stays at or below n. The remainder
// for each trial divisor comes from a restoring divider that retires one bit per cycle.
// Composites stop at their smallest odd factor. A new candidate is taken once the
// previous verdict has moved into the output register, which holds it until it is taken.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] candidate,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_prime,
  output logic [VALUE_BITS-1:0] tested_value
);

  localparam int SQ_BITS  = VALUE_BITS + 2;
  localparam int CNT_BITS = $clog2(VALUE_BITS);

  step_t                pc;
  step_t                pc_next;
  ctrl_t                cw;
  logic                 cond_hit;

  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [SQ_BITS-1:0]    sq;
  logic [VALUE_BITS-1:0] q;
  logic [VALUE_BITS:0]   rem;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_next;
  logic [CNT_BITS-1:0]   cnt;
  logic                  verdict;
  logic                  out_free;

  assign cw       = ucode_rom(pc);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (pc == S_WAIT);

  assign rem_shift = {rem[VALUE_BITS-1:0], q[VALUE_BITS-1]};
  assign rem_next  = (rem_shift >= {1'b0, d}) ? rem_shift - {1'b0, d} : rem_shift;

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_ACCEPT:   cond_hit = in_valid;
      C_LT2:      cond_hit = (n < VALUE_BITS'(2));
      C_EQ2:      cond_hit = (n == VALUE_BITS'(2));
      C_EVEN:     cond_hit = !n[0];
      C_SQ_GT_N:  cond_hit = (sq > SQ_BITS'(n));
      C_DIV_LAST: cond_hit = (cnt == CNT_BITS'(VALUE_BITS - 1));
      C_REM_ZERO: cond_hit = (rem == '0);
      C_OUT_FREE: cond_hit = out_free;
      default:    cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? cw.jump_true : cw.jump_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.act)
      ACT_LOAD: begin
        if (in_valid) n <= candidate;
      end
      ACT_INIT_D: begin
        d  <= VALUE_BITS'(3);
        sq <= SQ_BITS'(9);
      end
      ACT_DIV_START: begin
        rem <= '0;
        q   <= n;
        cnt <= '0;
      end
      ACT_DIV_STEP: begin
        rem <= rem_next;
        q   <= {q[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt + CNT_BITS'(1);
      end
      ACT_NEXT_D: begin
        d  <= d + VALUE_BITS'(2);
        sq <= sq + (SQ_BITS'(d) << 2) + SQ_BITS'(4);
      end
      ACT_SET_FAIL: verdict <= 1'b0;
      ACT_SET_PASS: verdict <= 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.act == ACT_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_EMIT && out_free) begin
      is_prime     <= verdict;
      tested_value <= n;
    end
  end

endmodule

/* bench/prime_verdict_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the primality verdict of each candidate word and compares the returned word.
module prime_verdict_checker #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [W-1:0] candidate,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic         is_prime,
  input  logic [W-1:0] tested_value,
  output int           fail_count,
  output int           awaited
);

  typedef struct packed {
    logic         prime;
    logic [W-1:0] value;
  } verdict_t;

  verdict_t verdict_q[$];

  function automatic logic prime_by_division(input logic [W-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    if (v == 2) return 1'b1;
    if (v % 2 == 0) return 1'b0;
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    bit       bad;
    if (rst) begin
      fail_count = 0;
    end else begin
      // retire the oldest expectation before queueing a new one
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got is_prime %0b tested_value %0d",
                   $time, is_prime, tested_value);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          bad  = 1'b0;
          if (is_prime !== want.prime) begin
            $display("%0t: is_prime of %0d: expected %0b, got %0b",
                     $time, want.value, want.prime, is_prime);
            bad = 1'b1;
          end
          if (tested_value !== want.value) begin
            $display("%0t: tested_value: expected %0d, got %0d",
                     $time, want.value, tested_value);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
      if (in_valid && in_ready) begin
        want.prime = prime_by_division(candidate);
        want.value = candidate;
        verdict_q.insert(verdict_q.size(), want);
      end
    end
    awaited = verdict_q.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top: drives candidate words into the prime test and reports the verdict of the run.
module tb_top;
  import tdpt_pkg::*;

  localparam int W           = VALUE_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int RANDOM_WORDS = 100;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  logic [W-1:0] candidate = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         is_prime;
  logic [W-1:0] tested_value;

  int fail_count;
  int awaited;
  int cycles     = 0;
  int stall_left = 0;
  bit calm       = 1'b0;

  logic [W-1:0] corner_values [18] = '{
    20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd7, 20'd9, 20'd25, 20'd97, 20'd121,
    20'd65537, 20'd524287, 20'd524288, 20'd1018081, 20'd1048573, 20'd1048574, 20'd1048575
  };

  always #6 clk = ~clk;

  trial_division_prime_test #(
    .VALUE_BITS(W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .candidate   (candidate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_prime    (is_prime),
    .tested_value(tested_value)
  );

  prime_verdict_checker #(
    .W(W)
  ) verdicts (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .candidate   (candidate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_prime    (is_prime),
    .tested_value(tested_value),
    .fail_count  (fail_count),
    .awaited     (awaited)
  );

  // stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic offer_candidate(input logic [W-1:0] n);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [W-1:0] pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) offer_candidate(corner_values[i]);

    // mostly small values; a few full-width ones reach every bit
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= RANDOM_WORDS - 20);
      case ($urandom_range(0, 9))
        7: pick = W'($urandom_range(0, 2047) * 2 + 1);
        8: pick = W'($urandom());
        9: begin
          pick    = W'($urandom());
          pick[0] = 1'b1;
        end
        default: pick = W'($urandom_range(0, 4095));
      endcase
      offer_candidate(pick);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
